// ===== rtl/core/text_console_glyph_renderer_assert.svh =====
// ----------------------------------------------------------------------------
// Text console glyph renderer assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst_n low.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// Same-cycle implication
`define TCGR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TCGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, constants and the 8x8 glyph table of the glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcgr_pkg;

    // Field and state widths
    localparam int CUR_W      = 12;
    localparam int DIM_W      = 13;
    localparam int PITCH_W    = 15;
    localparam int ADDR_W     = 24;
    localparam int BITS_W     = 8;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;

    // Glyph geometry
    localparam int GLYPH_SIZE    = 8;
    localparam int SCALE_DEFAULT = 2;
    localparam int ROW_IDX_W     = $clog2(GLYPH_SIZE);

    // Tab expands to this many spaces
    localparam int TAB_SPACES = 4;
    localparam int REPS_W     = $clog2(TAB_SPACES + 1);

    // Register reset values
    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd1024;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd768;
    localparam logic [PITCH_W-1:0] PITCH_RESET  = 15'd4096;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // Result kinds
    localparam logic KIND_ROW   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE        = 4'd0,
        REG_SCREEN_WIDTH  = 4'd1,
        REG_SCREEN_HEIGHT = 4'd2,
        REG_LINE_PITCH    = 4'd3
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW,
        S_ROWS,
        S_ADV,
        S_LINE,
        S_CLR,
        S_FIN
    } state_t;

    // Kind of operation a character starts
    typedef enum logic [1:0] {
        OP_GLYPH,
        OP_BS,
        OP_NL
    } op_t;

    // Address unit control
    typedef struct packed {
        logic load;   // start a cell at the cursor row
        logic step;   // move to the next glyph row
    } addr_ctrl_t;

    // Eight glyph rows, index 0 is the top row
    typedef logic [0:GLYPH_SIZE-1][BITS_W-1:0] glyph_t;

    // Glyph table; codes without a pattern are blank
    function automatic glyph_t glyph_rows(input logic [CHAR_W-1:0] code);
        glyph_t g;
        case (code)
            8'h41:   g = 64'h18_24_42_7E_81_81_00_00;
            8'h42:   g = 64'h7C_42_42_7C_42_42_7C_00;
            8'h43:   g = 64'h3C_42_80_80_80_42_3C_00;
            8'h44:   g = 64'h7C_42_41_41_41_42_7C_00;
            8'h45:   g = 64'h7E_40_40_78_40_40_7E_00;
            8'h46:   g = 64'h7E_40_40_78_40_40_40_00;
            8'h47:   g = 64'h3C_42_80_8E_82_42_3C_00;
            8'h48:   g = 64'h42_42_42_7E_42_42_42_00;
            8'h49:   g = 64'h7C_10_10_10_10_10_7C_00;
            8'h4A:   g = 64'h0E_04_04_04_04_44_38_00;
            8'h4B:   g = 64'h42_44_48_70_48_44_42_00;
            8'h4C:   g = 64'h40_40_40_40_40_40_7E_00;
            8'h4D:   g = 64'h81_C3_A5_99_81_81_81_00;
            8'h4E:   g = 64'h42_62_52_4A_46_42_41_00;
            8'h4F:   g = 64'h3C_42_81_81_81_42_3C_00;
            8'h50:   g = 64'h7C_42_42_7C_40_40_40_00;
            8'h51:   g = 64'h3C_42_81_81_85_42_3A_00;
            8'h52:   g = 64'h7C_42_42_7C_48_44_42_00;
            8'h53:   g = 64'h3C_42_40_3C_02_42_3C_00;
            8'h54:   g = 64'h7E_10_10_10_10_10_10_00;
            8'h55:   g = 64'h81_81_81_81_81_42_3C_00;
            8'h56:   g = 64'h81_81_42_42_24_24_18_00;
            8'h57:   g = 64'h81_81_81_99_A5_C3_81_00;
            8'h58:   g = 64'h81_42_24_18_24_42_81_00;
            8'h59:   g = 64'h81_42_24_18_10_10_10_00;
            8'h5A:   g = 64'h7E_02_04_08_10_20_7E_00;
            8'h30:   g = 64'h3C_42_81_89_81_42_3C_00;
            8'h31:   g = 64'h08_18_08_08_08_08_3E_00;
            8'h32:   g = 64'h3C_42_02_3C_40_40_7E_00;
            8'h33:   g = 64'h3C_42_02_1C_02_42_3C_00;
            8'h34:   g = 64'h08_18_28_48_7E_08_08_00;
            8'h35:   g = 64'h7E_40_40_7C_02_42_3C_00;
            8'h36:   g = 64'h3C_42_40_7C_42_42_3C_00;
            8'h37:   g = 64'h7E_02_04_08_10_20_40_00;
            8'h38:   g = 64'h3C_42_42_3C_42_42_3C_00;
            8'h39:   g = 64'h3C_42_42_3E_02_42_3C_00;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcgr_addr_gen.sv =====
// ----------------------------------------------------------------------------
// tcgr_addr_gen
// Byte address accumulator: row*pitch on load, then one scaled pitch per row.
// ----------------------------------------------------------------------------
`default_nettype none

module tcgr_addr_gen
    import tcgr_pkg::*;
#(
    parameter int SCALE = SCALE_DEFAULT
)
(
    input  wire logic                clk,
    input  wire addr_ctrl_t          ctrl,
    input  wire logic [CUR_W-1:0]    row,
    input  wire logic [CUR_W-1:0]    col,
    input  wire logic [PITCH_W-1:0]  pitch,
    output logic      [ADDR_W-1:0]   address
);

    logic [ADDR_W-1:0]          acc_reg;
    logic [ADDR_W-1:0]          acc_next;
    logic [CUR_W+PITCH_W-1:0]   product;
    logic [ADDR_W-1:0]          stride;

    // Start of cell and per-row stride
    assign product = row * pitch;
    assign stride  = ADDR_W'(pitch * SCALE);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = product[ADDR_W-1:0];
        end
        else if (ctrl.step)
        begin
            acc_next = acc_reg + stride;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Four bytes per pixel column
    assign address = acc_reg + ADDR_W'({col, 2'b00});

endmodule

`default_nettype wire

// ===== rtl/core/text_console_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Character stream to framebuffer glyph-row and clear commands.
// ----------------------------------------------------------------------------
// Each accepted character runs on a small sequencer around one address
// accumulator, and s_tready stays low until the character is finished. A
// printable character that fits steps through accept, a load of row*pitch into
// the accumulator, eight glyph rows at one per cycle while the hold stage can
// take them, a cursor advance, plus a line step and a clear when those happen,
// and a closing step that marks the final result with tlast. Tab runs the space
// sequence four times. Carriage return finishes in the accept cycle. Each result
// is held one stage so that tlast can be set on the last one.
// ----------------------------------------------------------------------------
`default_nettype none
`include "text_console_glyph_renderer_assert.svh"

module text_console_glyph_renderer
    import tcgr_pkg::*;
#(
    parameter int SCALE = SCALE_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    // Character input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [CHAR_W-1:0]      s_tdata,    // [7:0] char_code

    // Command output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [ADDR_W+BITS_W-1:0]    m_tdata,    // [23:0] address, [31:24] row_bits
    output logic                        m_tuser,    // [0] kind
    output logic                        m_tlast
);

    localparam int CELL     = GLYPH_SIZE * SCALE;
    localparam int CMP_W    = CUR_W + 2;
    localparam logic [ROW_IDX_W-1:0] ROW_LAST = ROW_IDX_W'(GLYPH_SIZE - 1);

    // Configuration registers
    logic                   enable_reg;
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic [PITCH_W-1:0]     pitch_reg;

    // Sequencer
    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    logic [CUR_W-1:0]       col_reg, col_next;
    logic [CUR_W-1:0]       row_reg, row_next;
    logic [CHAR_W-1:0]      code_reg, code_next;
    logic [REPS_W-1:0]      reps_reg, reps_next;
    logic [ROW_IDX_W-1:0]   row_idx_reg, row_idx_next;

    // Hold stage and output register
    logic                   pend_valid_reg;
    logic                   pend_kind_reg;
    logic [ADDR_W-1:0]      pend_addr_reg;
    logic [BITS_W-1:0]      pend_bits_reg;
    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [ADDR_W+BITS_W-1:0] out_data_reg;
    logic                   out_last_reg;

    // Control and compare terms
    logic                   s_fire;
    logic                   can_push;
    logic                   push_pend;
    logic                   gen_valid;
    logic                   gen_kind;
    logic                   fin_fire;
    logic                   fits;
    logic                   col_wrap;
    logic                   row_over;
    logic                   more_reps;
    logic [CMP_W-1:0]       cell_c;
    logic [CMP_W-1:0]       col_ext;
    logic [CMP_W-1:0]       row_ext;
    logic [CMP_W-1:0]       row_step;
    logic [CMP_W-1:0]       width_ext;
    logic [CMP_W-1:0]       height_ext;
    addr_ctrl_t             addr_ctrl;
    logic [ADDR_W-1:0]      cell_addr;
    glyph_t                 cur_glyph;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;

    // A new result may enter the hold stage when it is empty or can drain
    assign can_push  = !pend_valid_reg || !out_valid_reg || m_tready;

    // Cursor geometry compares
    assign cell_c     = CMP_W'(CELL);
    assign col_ext    = CMP_W'(col_reg);
    assign row_ext    = CMP_W'(row_reg);
    assign width_ext  = CMP_W'(width_reg);
    assign height_ext = CMP_W'(height_reg);
    assign row_step   = row_ext + cell_c;
    assign fits       = (col_ext + cell_c <= width_ext) && (row_ext + cell_c <= height_ext);
    assign col_wrap   = (col_ext + cell_c + cell_c) > width_ext;
    assign row_over   = (row_step + cell_c) > height_ext;
    assign more_reps  = (op_reg == OP_GLYPH) && (reps_reg > REPS_W'(1));

    assign cur_glyph  = glyph_rows(code_reg);

    // Address accumulator
    tcgr_addr_gen #(
        .SCALE   (SCALE)
    ) u_addr_gen (
        .clk     (clk),
        .ctrl    (addr_ctrl),
        .row     (row_reg),
        .col     (col_reg),
        .pitch   (pitch_reg),
        .address (cell_addr)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            pitch_reg  <= PITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:        enable_reg <= cfg_data[0];
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                REG_LINE_PITCH:    pitch_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire && enable_reg)
                begin
                    case (s_tdata)
                        CH_NEWLINE: state_next = S_LINE;
                        CH_RETURN:  state_next = S_IDLE;
                        default:    state_next = S_DRAW;
                    endcase
                end
            end
            S_DRAW:
            begin
                if (fits)
                    state_next = S_ROWS;
                else if (op_reg == OP_BS)
                    state_next = S_FIN;
                else
                    state_next = S_ADV;
            end
            S_ROWS:
            begin
                if (can_push && row_idx_reg == ROW_LAST)
                    state_next = (op_reg == OP_BS) ? S_FIN : S_ADV;
            end
            S_ADV:
            begin
                if (col_wrap)
                    state_next = S_LINE;
                else
                    state_next = more_reps ? S_DRAW : S_FIN;
            end
            S_LINE:
            begin
                if (row_over)
                    state_next = S_CLR;
                else
                    state_next = more_reps ? S_DRAW : S_FIN;
            end
            S_CLR:
            begin
                if (can_push)
                    state_next = more_reps ? S_DRAW : S_FIN;
            end
            S_FIN:
            begin
                if (can_push)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs and cursor updates
    always_comb
    begin
        op_next        = op_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        code_next      = code_reg;
        reps_next      = reps_reg;
        row_idx_next   = row_idx_reg;
        addr_ctrl      = '0;
        gen_valid      = 1'b0;
        gen_kind       = KIND_ROW;
        fin_fire       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_fire && enable_reg)
                begin
                    code_next = CH_SPACE;
                    reps_next = REPS_W'(1);
                    op_next   = OP_GLYPH;
                    case (s_tdata)
                        CH_NEWLINE:
                        begin
                            op_next  = OP_NL;
                            col_next = '0;
                        end
                        CH_RETURN:
                        begin
                            col_next = '0;
                        end
                        CH_BACKSPACE:
                        begin
                            op_next = OP_BS;
                            if (col_ext >= cell_c)
                                col_next = col_reg - CUR_W'(CELL);
                        end
                        CH_TAB:
                        begin
                            reps_next = REPS_W'(TAB_SPACES);
                        end
                        default:
                        begin
                            code_next = s_tdata;
                        end
                    endcase
                end
            end
            S_DRAW:
            begin
                if (fits)
                begin
                    addr_ctrl.load = 1'b1;
                    row_idx_next   = '0;
                end
            end
            S_ROWS:
            begin
                if (can_push)
                begin
                    gen_valid      = 1'b1;
                    addr_ctrl.step = 1'b1;
                    row_idx_next   = row_idx_reg + ROW_IDX_W'(1);
                end
            end
            S_ADV:
            begin
                if (col_wrap)
                begin
                    col_next = '0;
                end
                else
                begin
                    col_next = col_reg + CUR_W'(CELL);
                    if (more_reps)
                        reps_next = reps_reg - REPS_W'(1);
                end
            end
            S_LINE:
            begin
                if (!row_over)
                begin
                    row_next = row_step[CUR_W-1:0];
                    if (more_reps)
                        reps_next = reps_reg - REPS_W'(1);
                end
            end
            S_CLR:
            begin
                if (can_push)
                begin
                    gen_valid = 1'b1;
                    gen_kind  = KIND_CLEAR;
                    col_next  = '0;
                    row_next  = '0;
                    if (more_reps)
                        reps_next = reps_reg - REPS_W'(1);
                end
            end
            S_FIN:
            begin
                fin_fire = can_push;
            end
            default: ;
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_GLYPH;
            col_reg     <= '0;
            row_reg     <= '0;
            code_reg    <= CH_SPACE;
            reps_reg    <= '0;
            row_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            code_reg    <= code_next;
            reps_reg    <= reps_next;
            row_idx_reg <= row_idx_next;
        end
    end

    // Hold stage drains into the output register on a new result or at finish
    assign push_pend = pend_valid_reg && (gen_valid || fin_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (gen_valid)
                pend_valid_reg <= 1'b1;
            else if (fin_fire)
                pend_valid_reg <= 1'b0;

            if (push_pend)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (gen_valid)
        begin
            pend_kind_reg <= gen_kind;
            pend_addr_reg <= (gen_kind == KIND_CLEAR) ? '0 : cell_addr;
            pend_bits_reg <= (gen_kind == KIND_CLEAR) ? '0 : cur_glyph[row_idx_reg];
        end
        if (push_pend)
        begin
            out_kind_reg <= pend_kind_reg;
            out_data_reg <= {pend_bits_reg, pend_addr_reg};
            out_last_reg <= fin_fire;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `TCGR_ASSERT_IMP(a_idle_hold_empty, s_tready, !pend_valid_reg,
        "character accepted while a result is still held")
    `TCGR_ASSERT_IMP(a_clear_zero, m_tvalid && m_tuser == KIND_CLEAR, m_tdata == '0,
        "clear command carries nonzero address or pattern")
    `TCGR_ASSERT_IMP(a_nonlast_has_follower, m_tvalid && !m_tlast, pend_valid_reg,
        "non-final result shown with no later result held")
    `TCGR_ASSERT_NEXT(a_rows_end, state_reg == S_ROWS && gen_valid && row_idx_reg == ROW_LAST,
        state_reg != S_ROWS, "glyph row sequence ran past the last row")
    `TCGR_ASSERT_NEXT(a_disabled_still, s_fire && !enable_reg,
        $stable(col_reg) && $stable(row_reg), "cursor moved while disabled")

endmodule

`default_nettype wire
